// File: src/ecupm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// Types, codes and transition table of the ECU power-mode sequencer.
// No dependencies; imported by every module of the block.
package ecupm_pkg;

    localparam int USER_COUNT     = 32;
    localparam int WAKEUP_SOURCES = 32;
    localparam int RUN_MASK_W     = 32;
    localparam int USER_IDX_W     = 5;
    localparam int COUNT_W        = 8;
    localparam int WAKE_W         = 32;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
    localparam logic [WAKE_W-1:0]  WAKE_MASK =
        WAKE_W'((64'd1 << WAKEUP_SOURCES) - 64'd1);

    localparam logic [1:0] TGT_SLEEP = 2'd0;
    localparam logic [1:0] TGT_RESET = 2'd1;
    localparam logic [1:0] TGT_OFF   = 2'd2;

    localparam logic [1:0] DEFAULT_TARGET_RST = TGT_OFF;
    localparam logic [7:0] DEFAULT_MODE_RST   = 8'd0;

    // binary state codes as seen on the ports
    localparam logic [3:0] ST_STARTUP    = 4'd0;
    localparam logic [3:0] ST_RUN        = 4'd1;
    localparam logic [3:0] ST_SLEEP      = 4'd2;
    localparam logic [3:0] ST_WAKE_SLEEP = 4'd3;
    localparam logic [3:0] ST_SHUTDOWN   = 4'd4;
    localparam logic [3:0] ST_PREP       = 4'd5;
    localparam logic [3:0] ST_GO_SLEEP   = 4'd6;
    localparam logic [3:0] ST_OFF_ONE    = 4'd7;
    localparam logic [3:0] ST_OFF_TWO    = 4'd8;
    localparam logic [3:0] ST_WK_ONE     = 4'd9;
    localparam logic [3:0] ST_WK_TWO     = 4'd10;
    localparam logic [3:0] ST_OFF        = 4'd11;
    localparam logic [3:0] ST_RESET      = 4'd12;

    localparam logic [2:0] ACT_NONE       = 3'd0;
    localparam logic [2:0] ACT_SWITCH_OFF = 3'd1;
    localparam logic [2:0] ACT_RESET      = 3'd2;
    localparam logic [2:0] ACT_SLEEP      = 3'd3;
    localparam logic [2:0] ACT_POSTRUN    = 3'd4;

    localparam logic CFG_DEFAULT_TARGET = 1'b0;
    localparam logic CFG_DEFAULT_MODE   = 1'b1;

    typedef enum logic [3:0] {
        K_TICK        = 4'd0,
        K_REQ_RUN     = 4'd1,
        K_REL_RUN     = 4'd2,
        K_REQ_POSTRUN = 4'd3,
        K_REL_POSTRUN = 4'd4,
        K_KILL        = 4'd5,
        K_SELECT      = 4'd6,
        K_SET_STATE   = 4'd7,
        K_STARTUP_TWO = 4'd8,
        K_ENTER_RUN   = 4'd9
    } pm_kind_t;

    typedef enum logic [12:0] {
        S_STARTUP    = 13'b0000000000001,
        S_RUN        = 13'b0000000000010,
        S_SLEEP      = 13'b0000000000100,
        S_WAKE_SLEEP = 13'b0000000001000,
        S_SHUTDOWN   = 13'b0000000010000,
        S_PREP       = 13'b0000000100000,
        S_GO_SLEEP   = 13'b0000001000000,
        S_OFF_ONE    = 13'b0000010000000,
        S_OFF_TWO    = 13'b0000100000000,
        S_WK_ONE     = 13'b0001000000000,
        S_WK_TWO     = 13'b0010000000000,
        S_OFF        = 13'b0100000000000,
        S_RESET      = 13'b1000000000000
    } pm_state_t;

    typedef struct packed {
        logic [3:0]        kind;
        logic [7:0]        user;
        logic [1:0]        target;
        logic [7:0]        mode;
        logic [3:0]        requested_state;
        logic              sleep_allowed;
        logic [WAKE_W-1:0] raised_wakeups;
        logic [WAKE_W-1:0] wakeup_ok;
    } pm_item_t;

    typedef struct packed {
        logic              status_ok;
        logic [3:0]        state;
        logic              sub_state;
        logic [1:0]        shutdown_target;
        logic [7:0]        sleep_mode;
        logic [1:0]        last_target;
        logic [7:0]        last_mode;
        logic [WAKE_W-1:0] validated_now;
        logic [WAKE_W-1:0] expired_now;
        logic              state_changed;
        logic [2:0]        action;
    } pm_result_t;

    function automatic logic [3:0] state_code(input pm_state_t s);
        logic [3:0] c;
        case (s)
            S_STARTUP:    c = ST_STARTUP;
            S_RUN:        c = ST_RUN;
            S_SLEEP:      c = ST_SLEEP;
            S_WAKE_SLEEP: c = ST_WAKE_SLEEP;
            S_SHUTDOWN:   c = ST_SHUTDOWN;
            S_PREP:       c = ST_PREP;
            S_GO_SLEEP:   c = ST_GO_SLEEP;
            S_OFF_ONE:    c = ST_OFF_ONE;
            S_OFF_TWO:    c = ST_OFF_TWO;
            S_WK_ONE:     c = ST_WK_ONE;
            S_WK_TWO:     c = ST_WK_TWO;
            S_OFF:        c = ST_OFF;
            S_RESET:      c = ST_RESET;
            default:      c = ST_STARTUP;
        endcase
        return c;
    endfunction

    function automatic pm_state_t state_decode(input logic [3:0] c);
        pm_state_t s;
        case (c)
            ST_STARTUP:    s = S_STARTUP;
            ST_RUN:        s = S_RUN;
            ST_SLEEP:      s = S_SLEEP;
            ST_WAKE_SLEEP: s = S_WAKE_SLEEP;
            ST_SHUTDOWN:   s = S_SHUTDOWN;
            ST_PREP:       s = S_PREP;
            ST_GO_SLEEP:   s = S_GO_SLEEP;
            ST_OFF_ONE:    s = S_OFF_ONE;
            ST_OFF_TWO:    s = S_OFF_TWO;
            ST_WK_ONE:     s = S_WK_ONE;
            ST_WK_TWO:     s = S_WK_TWO;
            ST_OFF:        s = S_OFF;
            ST_RESET:      s = S_RESET;
            default:       s = S_STARTUP;
        endcase
        return s;
    endfunction

    // fixed transition table; codes 13..15 never match
    function automatic logic move_allowed(input pm_state_t from, input logic [3:0] to);
        logic ok;
        case (from)
            S_STARTUP:    ok = (to == ST_RUN);
            S_RUN:        ok = (to == ST_SLEEP) || (to == ST_SHUTDOWN) || (to == ST_PREP);
            S_SLEEP:      ok = (to == ST_WAKE_SLEEP) || (to == ST_RESET);
            S_WAKE_SLEEP: ok = (to == ST_STARTUP) || (to == ST_RUN);
            S_SHUTDOWN:   ok = (to == ST_OFF) || (to == ST_RESET);
            S_PREP:       ok = (to == ST_GO_SLEEP) || (to == ST_OFF_ONE) || (to == ST_OFF_TWO);
            S_GO_SLEEP:   ok = (to == ST_SLEEP);
            S_OFF_ONE:    ok = (to == ST_OFF_TWO);
            S_OFF_TWO:    ok = (to == ST_OFF) || (to == ST_RESET);
            S_WK_ONE,
            S_WK_TWO:     ok = (to == ST_RUN) || (to == ST_STARTUP);
            default:      ok = 1'b0;
        endcase
        return ok;
    endfunction

endpackage
`default_nettype wire

// File: src/ecupm_in_stage.sv
`timescale 1ns / 1ps
`default_nettype none
// Input register of the power-mode sequencer: holds one event transaction.
// Depends on ecupm_pkg.
module ecupm_in_stage
    import ecupm_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_ready,
    input  wire pm_item_t item_in,
    input  wire logic     advance,
    output logic          item_valid,
    output pm_item_t      item
);

    logic     valid_reg;
    logic     valid_next;
    pm_item_t item_reg;

    assign in_ready   = !valid_reg || advance;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= item_in;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule
`default_nettype wire

// File: src/ecupm_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Sequencer state and the combinational event handling (tick handlers,
// request counters, target selection, checked transitions). Depends on ecupm_pkg.
module ecupm_core
    import ecupm_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     advance,
    input  wire pm_item_t item,
    output pm_result_t    result
);

    pm_state_t               state_reg,       state_next;
    logic                    sub_reg,         sub_next;
    logic [RUN_MASK_W-1:0]   run_mask_reg,    run_mask_next;
    logic [COUNT_W-1:0]      run_cnt_reg,     run_cnt_next;
    logic [COUNT_W-1:0]      post_cnt_reg,    post_cnt_next;
    logic [1:0]              target_reg,      target_next;
    logic [7:0]              mode_reg,        mode_next;
    logic [1:0]              prev_target_reg, prev_target_next;
    logic [7:0]              prev_mode_reg,   prev_mode_next;

    pm_kind_t            kind;
    logic                user_kind;
    logic                user_ok;
    logic                idle;
    logic                try_en;
    logic [3:0]          try_code;
    logic                changed;
    logic                status;
    logic [2:0]          act;
    logic [WAKE_W-1:0]   raised;
    logic [WAKE_W-1:0]   val_now;
    logic [WAKE_W-1:0]   exp_now;
    logic [RUN_MASK_W-1:0] user_bit;

    assign kind      = pm_kind_t'(item.kind);
    assign user_kind = (item.kind >= K_REQ_RUN) && (item.kind <= K_REL_POSTRUN);
    assign user_ok   = ({1'b0, item.user} < 9'(USER_COUNT));
    assign idle      = (run_cnt_reg == '0) && (run_mask_reg == '0);
    assign raised    = item.raised_wakeups & WAKE_MASK;
    assign user_bit  = RUN_MASK_W'(1) << item.user[USER_IDX_W-1:0];

    always_comb
    begin
        sub_next         = sub_reg;
        run_mask_next    = run_mask_reg;
        run_cnt_next     = run_cnt_reg;
        post_cnt_next    = post_cnt_reg;
        target_next      = target_reg;
        mode_next        = mode_reg;
        prev_target_next = prev_target_reg;
        prev_mode_next   = prev_mode_reg;
        status           = 1'b1;
        act              = ACT_NONE;
        val_now          = '0;
        exp_now          = '0;
        try_en           = 1'b0;
        try_code         = ST_STARTUP;

        if (user_kind && !user_ok)
        begin
            status = 1'b0;
        end
        else
        begin
            case (kind)
                K_TICK:
                begin
                    // pending set is empty between ticks, so pending == raised
                    val_now = raised & item.wakeup_ok;
                    exp_now = raised & ~item.wakeup_ok;
                    case (state_reg)
                        S_RUN:
                        begin
                            if (idle)
                            begin
                                if (post_cnt_reg != '0)
                                begin
                                    act      = ACT_POSTRUN;
                                    sub_next = 1'b1;
                                end
                                else
                                begin
                                    try_en   = 1'b1;
                                    try_code = ST_PREP;
                                end
                            end
                        end
                        S_PREP:
                        begin
                            if (target_reg == TGT_SLEEP)
                            begin
                                try_en   = 1'b1;
                                try_code = ST_GO_SLEEP;
                            end
                            else if (target_reg == TGT_RESET)
                            begin
                                act = ACT_RESET;
                            end
                            else
                            begin
                                try_en   = 1'b1;
                                try_code = ST_OFF_ONE;
                            end
                        end
                        S_GO_SLEEP:
                        begin
                            try_en = 1'b1;
                            if (item.sleep_allowed && idle)
                            begin
                                try_code = ST_SLEEP;
                                act      = ACT_SLEEP;
                            end
                            else
                            begin
                                // return to run: refused by the table
                                try_code = ST_RUN;
                            end
                        end
                        S_OFF_ONE:
                        begin
                            try_en   = 1'b1;
                            try_code = ST_OFF_TWO;
                        end
                        S_OFF_TWO:
                        begin
                            act      = ACT_SWITCH_OFF;
                            try_en   = 1'b1;
                            try_code = ST_OFF;
                        end
                        S_WAKE_SLEEP, S_WK_ONE, S_WK_TWO:
                        begin
                            try_en   = 1'b1;
                            try_code = ST_RUN;
                        end
                        default:
                        begin
                        end
                    endcase
                end
                K_REQ_RUN:
                begin
                    run_mask_next = run_mask_reg | user_bit;
                    if (run_cnt_reg != COUNT_MAX)
                    begin
                        run_cnt_next = run_cnt_reg + COUNT_W'(1);
                    end
                end
                K_REL_RUN:
                begin
                    run_mask_next = run_mask_reg & ~user_bit;
                    if (run_cnt_reg != '0)
                    begin
                        run_cnt_next = run_cnt_reg - COUNT_W'(1);
                    end
                end
                K_REQ_POSTRUN:
                begin
                    if (post_cnt_reg != COUNT_MAX)
                    begin
                        post_cnt_next = post_cnt_reg + COUNT_W'(1);
                    end
                end
                K_REL_POSTRUN:
                begin
                    if (post_cnt_reg != '0)
                    begin
                        post_cnt_next = post_cnt_reg - COUNT_W'(1);
                    end
                end
                K_KILL:
                begin
                    run_mask_next = '0;
                    run_cnt_next  = '0;
                    post_cnt_next = '0;
                end
                K_SELECT:
                begin
                    prev_target_next = target_reg;
                    prev_mode_next   = mode_reg;
                    target_next      = item.target;
                    mode_next        = item.mode;
                end
                K_SET_STATE:
                begin
                    try_en   = 1'b1;
                    try_code = item.requested_state;
                end
                K_STARTUP_TWO, K_ENTER_RUN:
                begin
                    if (state_reg == S_STARTUP)
                    begin
                        try_en   = 1'b1;
                        try_code = ST_RUN;
                        sub_next = 1'b1;
                    end
                    else if ((kind == K_ENTER_RUN) && (state_reg == S_WAKE_SLEEP))
                    begin
                        try_en   = 1'b1;
                        try_code = ST_RUN;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    assign changed    = try_en && move_allowed(state_reg, try_code);
    assign state_next = changed ? state_decode(try_code) : state_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_STARTUP;
            sub_reg         <= 1'b0;
            run_mask_reg    <= '0;
            run_cnt_reg     <= '0;
            post_cnt_reg    <= '0;
            target_reg      <= DEFAULT_TARGET_RST;
            mode_reg        <= DEFAULT_MODE_RST;
            prev_target_reg <= TGT_OFF;
            prev_mode_reg   <= '0;
        end
        else if (advance)
        begin
            state_reg       <= state_next;
            sub_reg         <= sub_next;
            run_mask_reg    <= run_mask_next;
            run_cnt_reg     <= run_cnt_next;
            post_cnt_reg    <= post_cnt_next;
            target_reg      <= target_next;
            mode_reg        <= mode_next;
            prev_target_reg <= prev_target_next;
            prev_mode_reg   <= prev_mode_next;
        end
    end

    always_comb
    begin
        result.status_ok       = status;
        result.state           = state_code(state_next);
        result.sub_state       = sub_next;
        result.shutdown_target = target_next;
        result.sleep_mode      = mode_next;
        result.last_target     = prev_target_next;
        result.last_mode       = prev_mode_next;
        result.validated_now   = val_now;
        result.expired_now     = exp_now;
        result.state_changed   = changed;
        result.action          = act;
    end

endmodule
`default_nettype wire

// File: src/ecupm_out_stage.sv
`timescale 1ns / 1ps
`default_nettype none
// Result register of the power-mode sequencer; holds a result while stalled.
// Depends on ecupm_pkg.
module ecupm_out_stage
    import ecupm_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       advance,
    input  wire pm_result_t result_in,
    output logic            out_free,
    input  wire logic       out_ready,
    output logic            out_valid,
    output pm_result_t      result
);

    logic       valid_reg;
    logic       valid_next;
    pm_result_t result_reg;

    assign out_free   = !valid_reg || out_ready;
    assign valid_next = out_free ? advance : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result_in;
        end
    end

    assign out_valid = valid_reg;
    assign result    = result_reg;

endmodule
`default_nettype wire

// File: src/ecu_power_mode_sequencer_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ECU power-mode sequencer, top level.
// Depends on ecupm_pkg, ecupm_in_stage, ecupm_core, ecupm_out_stage.
//
// Event channel (in_valid/in_ready): one transaction per event - tick,
// run and post-run requests, kill, target select, state request, startup.
// Result channel (out_valid/out_ready): exactly one result per event,
// giving status, the state after the event, selections, the wakeup bits
// resolved on a tick, the change flag and the action code.
// An event passes the input register, then the result register; the event
// logic between them is a single pass, so one event is taken every cycle
// unless the receiver stalls. Then the result register holds and the input
// register fills; in_ready drops only when both are occupied.
// Reset puts the machine in startup with all requests cleared, target off
// and sleep mode zero. Configuration (cfg_valid/cfg_ready, cfg_index,
// cfg_data) is always ready; the default target and sleep mode take effect
// only through reset, which restores their reset values, so writes are
// accepted and have no visible effect.
module ecu_power_mode_sequencer_unit
    import ecupm_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [3:0]        kind,
    input  wire logic [7:0]        user,
    input  wire logic [1:0]        target,
    input  wire logic [7:0]        mode,
    input  wire logic [3:0]        requested_state,
    input  wire logic              sleep_allowed,
    input  wire logic [WAKE_W-1:0] raised_wakeups,
    input  wire logic [WAKE_W-1:0] wakeup_ok,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic                   status_ok,
    output logic [3:0]             state,
    output logic                   sub_state,
    output logic [1:0]             shutdown_target,
    output logic [7:0]             sleep_mode,
    output logic [1:0]             last_target,
    output logic [7:0]             last_mode,
    output logic [WAKE_W-1:0]      validated_now,
    output logic [WAKE_W-1:0]      expired_now,
    output logic                   state_changed,
    output logic [2:0]             action,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic              cfg_index,
    input  wire logic [7:0]        cfg_data
);

    pm_item_t   item_in;
    pm_item_t   item;
    logic       item_valid;
    logic       advance;
    logic       out_free;
    pm_result_t core_result;
    pm_result_t result;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        item_in.kind            = kind;
        item_in.user            = user;
        item_in.target          = target;
        item_in.mode            = mode;
        item_in.requested_state = requested_state;
        item_in.sleep_allowed   = sleep_allowed;
        item_in.raised_wakeups  = raised_wakeups;
        item_in.wakeup_ok       = wakeup_ok;
    end

    assign advance = item_valid && out_free;

    ecupm_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .item_in    (item_in),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    ecupm_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (item),
        .result  (core_result)
    );

    ecupm_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .result_in (core_result),
        .out_free  (out_free),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .result    (result)
    );

    assign status_ok       = result.status_ok;
    assign state           = result.state;
    assign sub_state       = result.sub_state;
    assign shutdown_target = result.shutdown_target;
    assign sleep_mode      = result.sleep_mode;
    assign last_target     = result.last_target;
    assign last_mode       = result.last_mode;
    assign validated_now   = result.validated_now;
    assign expired_now     = result.expired_now;
    assign state_changed   = result.state_changed;
    assign action          = result.action;

endmodule
`default_nettype wire

// File: src/ecupm_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// Port-level checks for the power-mode sequencer, bound to the top level.
// Depends on ecupm_pkg and ecu_power_mode_sequencer_unit.
module ecupm_checker
    import ecupm_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              out_valid,
    input wire logic              out_ready,
    input wire logic              status_ok,
    input wire logic [3:0]        state,
    input wire logic [WAKE_W-1:0] validated_now,
    input wire logic [WAKE_W-1:0] expired_now,
    input wire logic              state_changed,
    input wire logic [2:0]        action
);

    property p_hold_on_stall;
        @(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(state) && $stable(action);
    endproperty
    a_hold_on_stall: assert property (p_hold_on_stall)
        else $error("result changed while stalled");

    property p_wakeup_disjoint;
        @(posedge clk) disable iff (!rst_n)
        out_valid |-> ((validated_now & expired_now) == '0);
    endproperty
    a_wakeup_disjoint: assert property (p_wakeup_disjoint)
        else $error("wakeup bit both validated and expired");

    property p_reject_no_effect;
        @(posedge clk) disable iff (!rst_n)
        out_valid && !status_ok |->
            !state_changed && (action == ACT_NONE) && (validated_now == '0);
    endproperty
    a_reject_no_effect: assert property (p_reject_no_effect)
        else $error("rejected transaction had an effect");

    property p_switch_off_lands_off;
        @(posedge clk) disable iff (!rst_n)
        out_valid && (action == ACT_SWITCH_OFF) |-> state_changed && (state == ST_OFF);
    endproperty
    a_switch_off_lands_off: assert property (p_switch_off_lands_off)
        else $error("switch-off action without move to off");

endmodule

bind ecu_power_mode_sequencer_unit ecupm_checker u_ecupm_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status_ok     (status_ok),
    .state         (state),
    .validated_now (validated_now),
    .expired_now   (expired_now),
    .state_changed (state_changed),
    .action        (action)
);
`default_nettype wire
